// File: rtl/assert_macros.svh
// assertion helpers used by access_pattern_classifier
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, skipped while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/apc_pkg.sv
// ----------------------------------------------------------------------------
// apc_pkg
// types and constants of the access pattern classifier
// ----------------------------------------------------------------------------
`default_nettype none
package apc_pkg;
	localparam int OFF_W = 40;
	localparam int SIZE_W = 32;
	localparam int PF_W = 43;
	// divider widths: dividend covers the size sum and the step sum
	localparam int DIV_W = 42;
	localparam int DVS_W = 7;
	localparam logic [PF_W-1:0] DEFAULT_PF = PF_W'(65536);

	typedef enum logic [0:0] {
		CMD_ACCESS = 1'b0,
		CMD_CLEAR  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		PAT_UNKNOWN    = 2'd0,
		PAT_SEQUENTIAL = 2'd1,
		PAT_STRIDED    = 2'd2,
		PAT_RANDOM     = 2'd3
	} pattern_t;

	typedef struct packed {
		logic [OFF_W-1:0]  offset;
		logic [SIZE_W-1:0] size;
	} entry_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [DVS_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_W-1:0]  quotient;
	} div_rsp_t;
endpackage
`default_nettype wire

// File: rtl/apc_if.sv
// ----------------------------------------------------------------------------
// apc_if
// valid/ready channels for access items and result items
// ----------------------------------------------------------------------------
`default_nettype none
interface apc_in_if;
	import apc_pkg::*;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic [OFF_W-1:0]   offset;
	logic [SIZE_W-1:0]  size;
	modport source (output valid, cmd, offset, size, input ready);
	modport sink (input valid, cmd, offset, size, output ready);
endinterface

interface apc_out_if;
	import apc_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         pattern;
	logic [PF_W-1:0]    prefetch_length;
	modport source (output valid, pattern, prefetch_length, input ready);
	modport sink (input valid, pattern, prefetch_length, output ready);
endinterface
`default_nettype wire

// File: rtl/apc_cell.sv
// ----------------------------------------------------------------------------
// apc_cell
// one window entry; loads a new access or takes its neighbor's entry
// ----------------------------------------------------------------------------
`default_nettype none
module apc_cell (
	input  wire logic            clk,
	input  wire logic            shift,
	input  wire logic            load,
	input  wire apc_pkg::entry_t nb,
	input  wire apc_pkg::entry_t ld,
	output apc_pkg::entry_t      q
);
	import apc_pkg::*;

	entry_t ent_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			ent_q <= nb;
		end else if (load) begin
			ent_q <= ld;
		end
	end

	assign q = ent_q;
endmodule
`default_nettype wire

// File: rtl/apc_div.sv
// ----------------------------------------------------------------------------
// apc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module apc_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire apc_pkg::div_req_t req,
	output apc_pkg::div_rsp_t     rsp
);
	import apc_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);

	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DIV_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[DVS_W]) begin
				rem_q <= diff[DVS_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DVS_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
endmodule
`default_nettype wire

// File: rtl/access_pattern_classifier.sv
// ----------------------------------------------------------------------------
// access_pattern_classifier
// sliding-window classifier of memory accesses with prefetch suggestion
// ----------------------------------------------------------------------------
// Each access item (offset, size) is appended to a window of the last WINDOW
// accesses held in a chain of cells, oldest in cell 0; a clear item empties
// the window and resets the class. Every item returns one result: the class
// (unknown, sequential, strided, random) and a suggested prefetch length.
// Items are handled one at a time. The window is read by rotating the chain
// once around in each pass; division runs on a shared one-bit-per-cycle
// divider of 42 steps. An access makes one pass, plus a mean division and a
// second pass when an analysis runs (every third access once four are held),
// plus a prefetch division when the class is strided; a clear item makes no
// pass. The result sits in an output register, so the next item may be
// worked on while it waits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module access_pattern_classifier #(
	parameter int WINDOW = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	apc_in_if.sink    access,
	apc_out_if.source result
);
	import apc_pkg::*;

	localparam int CW   = $clog2(WINDOW + 1);
	localparam int KW   = $clog2(WINDOW);
	localparam int SUMW = SIZE_W + CW;

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_PASS1   = 7'b0000010,
		S_DIVMEAN = 7'b0000100,
		S_PASS2   = 7'b0001000,
		S_DECIDE  = 7'b0010000,
		S_DIVPF   = 7'b0100000,
		S_FIN     = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// window chain
	entry_t            cell_q  [WINDOW];
	entry_t            new_ent;
	logic              full;
	logic              append;
	logic              rotate;

	logic [CW-1:0]     held_q;
	logic [4:0]        since_q;
	pattern_t          class_q;
	logic [SIZE_W-1:0] mean_q;

	// pass registers
	logic [KW-1:0]     k_q;
	logic [OFF_W-1:0]  prev_q;
	logic [SUMW-1:0]   sum_q;
	logic signed [OFF_W:0] first_q;
	logic [DIV_W-1:0]  pfsum_q;
	logic [CW-1:0]     seq_q;
	logic [CW-1:0]     strd_q;
	logic              cons_q;
	logic              go_q;

	// result register
	logic              ovalid_q;
	logic [1:0]        opat_q;
	logic [PF_W-1:0]   opf_q;

	div_req_t          dreq;
	div_rsp_t          drsp;

	logic              acc_hs;
	logic              in_rng;
	logic              k_last;
	logic              analyze;
	entry_t            head;
	logic signed [OFF_W:0]   d;
	logic [OFF_W-1:0]        abs_d;
	logic signed [OFF_W+1:0] dm, df;
	logic [OFF_W+1:0]        abs_dm, abs_df;
	logic [OFF_W+5:0]        ten_dm, ten_df;
	logic [OFF_W:0]          abs_first;
	logic                    is_seq, is_strd;
	logic [CW-1:0]           tcnt;
	logic [CW+3:0]           seq10, strd10, t7;
	pattern_t                new_class;
	logic [CW-1:0]           lim1;
	logic [PF_W-1:0]         pf_val;

	assign head    = cell_q[0];
	assign new_ent = '{offset: access.offset, size: access.size};
	assign full    = (held_q == CW'(WINDOW));
	assign acc_hs  = access.valid && access.ready;
	assign append  = acc_hs && (access.cmd == CMD_ACCESS);
	assign rotate  = (state_q == S_PASS1) || (state_q == S_PASS2);
	assign access.ready = (state_q == S_IDLE);

	// cells shift toward cell 0; the last cell takes the new access when full,
	// or the head entry while the chain rotates
	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		entry_t nb_in;
		logic   ld_en;
		if (i == WINDOW - 1) begin : g_last
			assign nb_in = rotate ? cell_q[0] : new_ent;
		end else begin : g_mid
			assign nb_in = cell_q[i+1];
		end
		assign ld_en = append && !full && (held_q == CW'(i));
		apc_cell u_cell (
			.clk   (clk),
			.shift (rotate || (append && full)),
			.load  (ld_en),
			.nb    (nb_in),
			.ld    (new_ent),
			.q     (cell_q[i])
		);
	end

	assign in_rng = (CW'(k_q) < held_q);
	assign k_last = (k_q == KW'(WINDOW - 1));
	assign analyze = (held_q >= CW'(4)) && (since_q >= 5'd3);

	// step and its magnitude
	assign d      = $signed({1'b0, head.offset}) - $signed({1'b0, prev_q});
	assign abs_d  = d[OFF_W] ? OFF_W'(-d) : d[OFF_W-1:0];

	// step tests against the mean size and the first step
	assign dm        = $signed({d[OFF_W], d}) - $signed({10'b0, mean_q});
	assign abs_dm    = dm[OFF_W+1] ? (OFF_W+2)'(-dm) : dm;
	assign ten_dm    = ({4'b0, abs_dm} << 3) + ({4'b0, abs_dm} << 1);
	assign is_seq    = (ten_dm <= {14'b0, mean_q});
	assign df        = $signed({d[OFF_W], d}) - $signed({first_q[OFF_W], first_q});
	assign abs_df    = df[OFF_W+1] ? (OFF_W+2)'(-df) : df;
	assign ten_df    = ({4'b0, abs_df} << 3) + ({4'b0, abs_df} << 1);
	assign abs_first = first_q[OFF_W] ? (OFF_W+1)'(-first_q) : first_q;
	assign is_strd   = (ten_df <= {5'b0, abs_first});

	// class vote
	assign tcnt   = held_q - 1'b1;
	assign seq10  = ({4'b0, seq_q} << 3) + ({4'b0, seq_q} << 1);
	assign strd10 = ({4'b0, strd_q} << 3) + ({4'b0, strd_q} << 1);
	assign t7     = ({4'b0, tcnt} << 3) - {4'b0, tcnt};
	always_comb begin
		if (seq10 >= t7) begin
			new_class = PAT_SEQUENTIAL;
		end else if (cons_q && (strd10 >= t7)) begin
			new_class = PAT_STRIDED;
		end else begin
			new_class = PAT_RANDOM;
		end
	end

	// strided prefetch averages the oldest up to four steps
	assign lim1 = (held_q >= CW'(5)) ? CW'(4) : (held_q - 1'b1);

	always_comb begin
		case (class_q)
			PAT_SEQUENTIAL: pf_val = {8'b0, mean_q, 3'b0};
			PAT_STRIDED:    pf_val = {drsp.quotient[PF_W-3:0], 2'b0};
			default:        pf_val = DEFAULT_PF;
		endcase
	end

	always_comb begin
		dreq.start = go_q;
		if (state_q == S_DIVMEAN) begin
			dreq.dividend = DIV_W'(sum_q);
			dreq.divisor  = DVS_W'(held_q);
		end else begin
			dreq.dividend = pfsum_q;
			dreq.divisor  = DVS_W'(lim1);
		end
	end

	apc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc_hs) begin
					state_d = (access.cmd == CMD_CLEAR) ? S_FIN : S_PASS1;
				end
			end
			S_PASS1: begin
				if (k_last) begin
					if (analyze) begin
						state_d = S_DIVMEAN;
					end else if (class_q == PAT_STRIDED && held_q >= CW'(2)) begin
						state_d = S_DIVPF;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_DIVMEAN: begin
				if (drsp.done) begin
					state_d = S_PASS2;
				end
			end
			S_PASS2: begin
				if (k_last) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_d = (new_class == PAT_STRIDED) ? S_DIVPF : S_FIN;
			end
			S_DIVPF: begin
				if (drsp.done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!ovalid_q || result.ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			held_q   <= '0;
			since_q  <= '0;
			class_q  <= PAT_UNKNOWN;
			mean_q   <= '0;
			k_q      <= '0;
			go_q     <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			go_q    <= ((state_d == S_DIVMEAN) || (state_d == S_DIVPF)) && (state_d != state_q);
			if (rotate) begin
				k_q <= k_last ? '0 : k_q + 1'b1;
			end
			if (acc_hs) begin
				if (access.cmd == CMD_CLEAR) begin
					held_q  <= '0;
					since_q <= '0;
					class_q <= PAT_UNKNOWN;
					mean_q  <= '0;
				end else begin
					held_q <= full ? held_q : held_q + 1'b1;
					if (since_q != 5'd31) begin
						since_q <= since_q + 1'b1;
					end
				end
			end
			if (state_q == S_DIVMEAN && drsp.done) begin
				mean_q <= drsp.quotient[SIZE_W-1:0];
			end
			if (state_q == S_DECIDE) begin
				class_q <= new_class;
				since_q <= '0;
			end
			if (result.valid && result.ready) begin
				ovalid_q <= 1'b0;
			end
			if (state_q == S_FIN && (!ovalid_q || result.ready)) begin
				ovalid_q <= 1'b1;
			end
		end
	end

	// pass accumulators
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			sum_q   <= '0;
			pfsum_q <= '0;
			seq_q   <= '0;
			strd_q  <= '0;
			cons_q  <= 1'b1;
		end
		if (rotate && in_rng) begin
			prev_q <= head.offset;
		end
		if (state_q == S_PASS1 && in_rng) begin
			sum_q <= sum_q + SUMW'(head.size);
			if (k_q == KW'(1)) begin
				first_q <= d;
			end
			if (k_q != '0 && k_q <= KW'(4)) begin
				pfsum_q <= pfsum_q + DIV_W'(abs_d);
			end
		end
		if (state_q == S_PASS2 && in_rng && k_q != '0) begin
			if (is_seq) begin
				seq_q <= seq_q + 1'b1;
			end else if (is_strd) begin
				strd_q <= strd_q + 1'b1;
			end else begin
				cons_q <= 1'b0;
			end
		end
		if (state_q == S_FIN && (!ovalid_q || result.ready)) begin
			opat_q <= class_q;
			opf_q  <= pf_val;
		end
	end

	assign result.valid           = ovalid_q;
	assign result.pattern         = opat_q;
	assign result.prefetch_length = opf_q;

	`ASSERT_CLK(a_held_bound, held_q <= CW'(WINDOW), "held count above window depth")
	`ASSERT_CLK(a_accept_leaves_idle, acc_hs |=> (state_q != S_IDLE), "item accepted but idle")
	`ASSERT_CLK(a_no_pending_analysis, (state_q == S_IDLE) |-> !analyze, "analysis left pending")
	`ASSERT_CLK(a_div_done_owner, drsp.done |-> (state_q == S_DIVMEAN || state_q == S_DIVPF),
		"divider result with no waiting state")
endmodule
`default_nettype wire
